// File: design/cgc_pkg.sv
// ----------------------------------------------------------------------------
// Crossfader gain curve package
// Shared widths, register indexes, payload structs and constant functions.
// ----------------------------------------------------------------------------
package cgc_pkg;

  localparam int FRAC           = 24;
  localparam int GAIN_FRAC_BITS = 15;
  localparam int POS_W          = 17;
  localparam int EXP_W          = 18;
  localparam int CAL_W          = 17;
  localparam int GAIN_W         = 16;
  localparam int MAG_W          = FRAC + 2;
  localparam int Q_W            = FRAC + 1;
  localparam int LOG_W          = FRAC + 5;
  localparam int RES_W          = 33;
  localparam int SQ_W           = 2 * Q_W;
  localparam int NUM_W          = FRAC + Q_W;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = EXP_W;

  localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC;

  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CALIBRATION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP        = 2'd3;

  typedef struct packed {
    logic [EXP_W-1:0] exponent;
    logic [CAL_W-1:0] calibration;
    logic             cp;
    logic             swap;
  } cfg_t;

  typedef struct packed {
    logic             act;
    logic [MAG_W-1:0] mag;
  } side_t;

  typedef struct packed {
    logic            pz;
    logic            ps;
    logic [4:0]      whole;
    logic [FRAC-1:0] frac;
  } log_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // Factor 2^-(2^-idx) in Q.32, each the floor square root of the one before.
  function automatic logic [31:0] exp_factor(input int unsigned idx);
    logic [63:0] f;
    f = 64'd1 << 31;
    for (int unsigned i = 1; i <= idx; i++) begin
      f = isqrt64(f << 32);
    end
    return f[31:0];
  endfunction

endpackage

// File: design/cgc_front.sv
// ----------------------------------------------------------------------------
// Crossfader front end
// Saturates the position, applies the constant power calibration in that mode and
// produces the magnitude seen by each side.
// ----------------------------------------------------------------------------
module cgc_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic signed [cgc_pkg::POS_W-1:0] pos,
  input  cgc_pkg::cfg_t                    cfg,
  output logic                             out_vld,
  output cgc_pkg::side_t                   side_a,
  output cgc_pkg::side_t                   side_b
);
  import cgc_pkg::*;

  localparam logic signed [POS_W-1:0] POS_MAX = 17'sd32768;
  localparam logic signed [POS_W-1:0] POS_MIN = -17'sd32768;
  localparam logic [CAL_W-1:0]        CAL_MAX = 17'd65536;

  logic signed [POS_W-1:0] pos_sat;
  logic signed [POS_W-1:0] pos_abs;
  logic [CAL_W-1:0]        cal_sat;

  logic                    v1;
  logic                    neg1;
  logic signed [POS_W-1:0] pos1;
  logic [CAL_W-1:0]        cal1;
  logic [32:0]             prod1;

  logic [32:0]        rnd;
  logic [Q_W-1:0]     r_mag;
  logic signed [26:0] p;
  logic signed [26:0] c24;
  logic signed [26:0] left;
  logic signed [26:0] right;
  logic signed [26:0] neg_left;

  always_comb begin
    if (pos < POS_MIN) pos_sat = POS_MIN;
    else if (pos > POS_MAX) pos_sat = POS_MAX;
    else pos_sat = pos;
    pos_abs = pos_sat[POS_W-1] ? -pos_sat : pos_sat;
    cal_sat = (cfg.calibration > CAL_MAX) ? CAL_MAX : cfg.calibration;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
    end
    if (en) begin
      neg1  <= pos_sat[POS_W-1];
      pos1  <= pos_sat;
      cal1  <= cal_sat;
      prod1 <= 33'(pos_abs[POS_W-1:0]) * 33'(cal_sat);
    end
  end

  always_comb begin
    rnd      = prod1 + 33'd64;
    r_mag    = rnd[31:7];
    p        = neg1 ? -$signed({2'b00, r_mag}) : $signed({2'b00, r_mag});
    c24      = $signed({2'b00, cal1, 8'h00});
    if (cfg.cp) begin
      left  = p - c24;
      right = p + c24;
    end else begin
      left  = $signed({pos1[POS_W-1], pos1, 9'h000});
      right = left;
    end
    neg_left = -left;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= v1;
    end
    if (en) begin
      side_b.act <= left[26];
      side_b.mag <= neg_left[MAG_W-1:0];
      side_a.act <= !right[26] && (right != '0);
      side_a.mag <= right[MAG_W-1:0];
    end
  end

endmodule

// File: design/cgc_log.sv
// ----------------------------------------------------------------------------
// Crossfader log2 unit
// Normalizes the magnitude and extracts 24 fraction bits of its log2,
// one squaring per pipeline stage.
// ----------------------------------------------------------------------------
module cgc_log (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_vld,
  input  cgc_pkg::side_t               side,
  input  logic [cgc_pkg::EXP_W-1:0]    exponent,
  output logic                         out_vld,
  output cgc_pkg::log_t                lg
);
  import cgc_pkg::*;

  logic [4:0]      n_c;
  logic            v0;
  logic [4:0]      n0;
  logic [FRAC-1:0] m0;
  logic            pz0;
  logic            ps0;
  logic [2*FRAC:0] shl;

  logic [Q_W-1:0]  y   [0:FRAC];
  logic [FRAC-1:0] fr  [0:FRAC];
  logic            vl  [0:FRAC];
  logic            pz  [0:FRAC];
  logic            ps  [0:FRAC];
  logic [4:0]      wh  [0:FRAC];

  always_comb begin
    n_c = '0;
    for (int i = 1; i < FRAC; i++) begin
      if (side.mag[i]) n_c = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_vld;
    end
    if (en) begin
      m0  <= side.mag[FRAC-1:0];
      n0  <= n_c;
      ps0 <= side.act && ((side.mag >= MAG_W'(ONE_Q)) || (exponent == '0));
      pz0 <= !side.act || ((side.mag == '0) && (exponent != '0));
    end
  end

  assign shl = {{(FRAC+1){1'b0}}, m0} << (5'(FRAC) - n0);

  always_ff @(posedge clk) begin
    if (rst) begin
      vl[0] <= 1'b0;
    end else if (en) begin
      vl[0] <= v0;
    end
    if (en) begin
      y[0]  <= shl[Q_W-1:0];
      fr[0] <= '0;
      pz[0] <= pz0;
      ps[0] <= ps0;
      wh[0] <= 5'(FRAC) - n0;
    end
  end

  for (genvar j = 0; j < FRAC; j++) begin : g_sq
    logic [SQ_W-1:0] yz;
    logic [SQ_W-1:0] sq;
    logic [FRAC+1:0] t;

    assign yz = SQ_W'(y[j]);
    assign sq = yz * yz;
    assign t  = sq[2*FRAC+1:FRAC];

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[j+1] <= 1'b0;
      end else if (en) begin
        vl[j+1] <= vl[j];
      end
      if (en) begin
        y[j+1]  <= t[FRAC+1] ? t[FRAC+1:1] : t[FRAC:0];
        fr[j+1] <= {fr[j][FRAC-2:0], t[FRAC+1]};
        pz[j+1] <= pz[j];
        ps[j+1] <= ps[j];
        wh[j+1] <= wh[j];
      end
    end
  end

  assign out_vld  = vl[FRAC];
  assign lg.pz    = pz[FRAC];
  assign lg.ps    = ps[FRAC];
  assign lg.whole = wh[FRAC];
  assign lg.frac  = fr[FRAC];

endmodule

// File: design/cgc_exp.sv
// ----------------------------------------------------------------------------
// Crossfader power unit
// Scales the log by the exponent and rebuilds 2^-u one fraction bit per
// stage, then forms the side gain 1 - |x|^e.
// ----------------------------------------------------------------------------
module cgc_exp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_vld,
  input  cgc_pkg::log_t             lg,
  input  logic [cgc_pkg::EXP_W-1:0] exponent,
  output logic                      out_vld,
  output logic [cgc_pkg::Q_W-1:0]   gain
);
  import cgc_pkg::*;

  localparam int UP_W = EXP_W + LOG_W + 1;

  logic             v0;
  logic [LOG_W-1:0] lmag0;
  logic             pz0;
  logic             ps0;
  logic [UP_W-1:0]  up;
  logic [15:0]      k_full;

  logic [RES_W-1:0] res  [0:FRAC];
  logic [FRAC-1:0]  fb   [0:FRAC];
  logic [4:0]       kk   [0:FRAC];
  logic             kbig [0:FRAC];
  logic             vl   [0:FRAC];
  logic             pz   [0:FRAC];
  logic             ps   [0:FRAC];

  logic             v2;
  logic [Q_W-1:0]   r24;
  logic [4:0]       k2;
  logic             z2;
  logic             ps2;
  logic [RES_W:0]   rr;

  logic             v3;
  logic [Q_W-1:0]   powv3;
  logic             z3;
  logic             ps3;
  logic [Q_W-1:0]   shv;
  logic [Q_W-1:0]   half;
  logic [Q_W-1:0]   pow_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_vld;
    end
    if (en) begin
      lmag0 <= {lg.whole, FRAC'(0)} - LOG_W'(lg.frac);
      pz0   <= lg.pz;
      ps0   <= lg.ps;
    end
  end

  assign up     = UP_W'(exponent) * UP_W'(lmag0) + UP_W'(128);
  assign k_full = up[UP_W-1:FRAC+8];

  always_ff @(posedge clk) begin
    if (rst) begin
      vl[0] <= 1'b0;
    end else if (en) begin
      vl[0] <= v0;
    end
    if (en) begin
      res[0]  <= RES_W'(1) << 32;
      fb[0]   <= up[FRAC+7:8];
      kk[0]   <= k_full[4:0];
      kbig[0] <= k_full > 16'(FRAC);
      pz[0]   <= pz0;
      ps[0]   <= ps0;
    end
  end

  for (genvar i = 0; i < FRAC; i++) begin : g_mul
    localparam logic [31:0] FCT = exp_factor(i + 1);
    logic [2*RES_W-2:0] prod;

    assign prod = (2*RES_W-1)'(res[i]) * (2*RES_W-1)'(FCT);

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i+1] <= 1'b0;
      end else if (en) begin
        vl[i+1] <= vl[i];
      end
      if (en) begin
        res[i+1]  <= fb[i][FRAC-1-i] ? prod[2*RES_W-2:32] : res[i];
        fb[i+1]   <= fb[i];
        kk[i+1]   <= kk[i];
        kbig[i+1] <= kbig[i];
        pz[i+1]   <= pz[i];
        ps[i+1]   <= ps[i];
      end
    end
  end

  assign rr = (RES_W+1)'(res[FRAC]) + (RES_W+1)'(128);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= vl[FRAC];
    end
    if (en) begin
      r24 <= rr[32:8];
      k2  <= kk[FRAC];
      z2  <= pz[FRAC] || kbig[FRAC];
      ps2 <= ps[FRAC];
    end
  end

  always_comb begin
    half = r24 >> (k2 - 5'd1);
    shv  = (k2 == '0) ? r24 : Q_W'((half + Q_W'(1)) >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      powv3 <= (shv > ONE_Q) ? ONE_Q : shv;
      z3    <= z2;
      ps3   <= ps2;
    end
  end

  always_comb begin
    if (ps3) pow_c = ONE_Q;
    else if (z3) pow_c = '0;
    else pow_c = powv3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= v3;
    end
    if (en) begin
      gain <= ONE_Q - pow_c;
    end
  end

endmodule

// File: design/cgc_norm.sv
// ----------------------------------------------------------------------------
// Crossfader constant power normalizer
// In constant power mode balances the gains, takes the square root of their
// power sum, divides both by it, swaps if set and rounds to the output format.
// ----------------------------------------------------------------------------
module cgc_norm (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [cgc_pkg::Q_W-1:0]      ga,
  input  logic [cgc_pkg::Q_W-1:0]      gb,
  input  logic                         cp,
  input  logic                         swap,
  output logic                         out_vld,
  output logic [cgc_pkg::GAIN_W-1:0]   gain_a,
  output logic [cgc_pkg::GAIN_W-1:0]   gain_b
);
  import cgc_pkg::*;

  localparam int          SH  = FRAC - GAIN_FRAC_BITS;
  localparam int unsigned RND = (SH > 0) ? (32'd1 << (SH - 1)) : 32'd0;
  localparam int          NS  = Q_W;

  logic           v0;
  logic [Q_W-1:0] a0;
  logic [Q_W-1:0] b0;

  logic [SQ_W-1:0] sv [0:NS];
  logic [SQ_W-1:0] sr [0:NS];
  logic [Q_W-1:0]  sa [0:NS];
  logic [Q_W-1:0]  sb [0:NS];
  logic            svl[0:NS];

  logic [SQ_W-1:0] ra [0:NS];
  logic [SQ_W-1:0] rb [0:NS];
  logic [Q_W-1:0]  qa [0:NS];
  logic [Q_W-1:0]  qb [0:NS];
  logic [Q_W-1:0]  dn [0:NS];
  logic [Q_W-1:0]  da [0:NS];
  logic [Q_W-1:0]  db [0:NS];
  logic            dvl[0:NS];

  logic [SQ_W-1:0] a0z;
  logic [SQ_W-1:0] b0z;
  logic [Q_W-1:0]  root;
  logic [Q_W-1:0]  fa;
  logic [Q_W-1:0]  fb;
  logic [Q_W-1:0]  ca;
  logic [Q_W-1:0]  cb;
  logic [Q_W:0]    oa;
  logic [Q_W:0]    ob;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_vld;
    end
    if (en) begin
      if (cp && (ga > gb)) begin
        a0 <= ga;
        b0 <= ONE_Q - ga;
      end else if (cp) begin
        a0 <= ONE_Q - gb;
        b0 <= gb;
      end else begin
        a0 <= ga;
        b0 <= gb;
      end
    end
  end

  assign a0z = SQ_W'(a0);
  assign b0z = SQ_W'(b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      svl[0] <= 1'b0;
    end else if (en) begin
      svl[0] <= v0;
    end
    if (en) begin
      sv[0] <= a0z * a0z + b0z * b0z;
      sr[0] <= '0;
      sa[0] <= a0;
      sb[0] <= b0;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (NS - 1 - s));
    logic [SQ_W-1:0] trial;

    assign trial = sr[s] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        svl[s+1] <= 1'b0;
      end else if (en) begin
        svl[s+1] <= svl[s];
      end
      if (en) begin
        if (sv[s] >= trial) begin
          sv[s+1] <= sv[s] - trial;
          sr[s+1] <= (sr[s] >> 1) + BIT;
        end else begin
          sv[s+1] <= sv[s];
          sr[s+1] <= sr[s] >> 1;
        end
        sa[s+1] <= sa[s];
        sb[s+1] <= sb[s];
      end
    end
  end

  assign root = sr[NS][Q_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dvl[0] <= 1'b0;
    end else if (en) begin
      dvl[0] <= svl[NS];
    end
    if (en) begin
      ra[0] <= SQ_W'({sa[NS], FRAC'(0)}) + SQ_W'(root >> 1);
      rb[0] <= SQ_W'({sb[NS], FRAC'(0)}) + SQ_W'(root >> 1);
      qa[0] <= '0;
      qb[0] <= '0;
      dn[0] <= root;
      da[0] <= sa[NS];
      db[0] <= sb[NS];
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_div
    logic [SQ_W-1:0] dsh;

    assign dsh = SQ_W'(dn[s]) << (NS - 1 - s);

    always_ff @(posedge clk) begin
      if (rst) begin
        dvl[s+1] <= 1'b0;
      end else if (en) begin
        dvl[s+1] <= dvl[s];
      end
      if (en) begin
        ra[s+1] <= (ra[s] >= dsh) ? ra[s] - dsh : ra[s];
        rb[s+1] <= (rb[s] >= dsh) ? rb[s] - dsh : rb[s];
        qa[s+1] <= {qa[s][Q_W-2:0], ra[s] >= dsh};
        qb[s+1] <= {qb[s][Q_W-2:0], rb[s] >= dsh};
        dn[s+1] <= dn[s];
        da[s+1] <= da[s];
        db[s+1] <= db[s];
      end
    end
  end

  always_comb begin
    if (cp && (dn[NS] != '0)) begin
      fa = qa[NS];
      fb = qb[NS];
    end else begin
      fa = da[NS];
      fb = db[NS];
    end
    ca = (fa > ONE_Q) ? ONE_Q : fa;
    cb = (fb > ONE_Q) ? ONE_Q : fb;
    if (swap) begin
      oa = ({1'b0, cb} + (Q_W+1)'(RND)) >> SH;
      ob = ({1'b0, ca} + (Q_W+1)'(RND)) >> SH;
    end else begin
      oa = ({1'b0, ca} + (Q_W+1)'(RND)) >> SH;
      ob = ({1'b0, cb} + (Q_W+1)'(RND)) >> SH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= dvl[NS];
    end
    if (en) begin
      gain_a <= oa[GAIN_W-1:0];
      gain_b <= ob[GAIN_W-1:0];
    end
  end

endmodule

// File: design/crossfader_gain_curve.sv
// ----------------------------------------------------------------------------
// Crossfader gain curve
// Maps a crossfader position to two channel gains, 1 - |x|^e per side, with
// an optional constant power normalization and a side swap.
// ----------------------------------------------------------------------------
// The block takes one position word per clock while the output is not stalled
// and returns one gain word per position. The pipeline is made up mainly of the
// 24 squaring stages of the log2 unit, the 24 multiply stages that rebuild the
// power, and the 25-step square root and dividers of the constant power
// normalizer. A stall on the output holds the whole pipeline.
// ----------------------------------------------------------------------------
module crossfader_gain_curve (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [23:0]                         s_tdata,   // position[16:0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [31:0]                         m_tdata,   // gain_a[15:0], gain_b[31:16]
  input  logic                                cfg_wr_en,
  input  logic [cgc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cgc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import cgc_pkg::*;

  cfg_t           cfg;
  logic           en;
  logic           f_vld;
  side_t          side_a;
  side_t          side_b;
  logic           la_vld;
  logic           lb_vld;
  log_t           lg_a;
  log_t           lg_b;
  logic           ea_vld;
  logic           eb_vld;
  logic [Q_W-1:0] ga;
  logic [Q_W-1:0] gb;
  logic [GAIN_W-1:0] gain_a;
  logic [GAIN_W-1:0] gain_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.exponent    <= 18'd256;
      cfg.calibration <= 17'd32768;
      cfg.cp          <= 1'b0;
      cfg.swap        <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_EXPONENT:    cfg.exponent    <= cfg_data;
        REG_CALIBRATION: cfg.calibration <= cfg_data[CAL_W-1:0];
        REG_MODE:        cfg.cp          <= cfg_data[0];
        REG_SWAP:        cfg.swap        <= cfg_data[0];
      endcase
    end
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  cgc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (s_tvalid),
    .pos     ($signed(s_tdata[POS_W-1:0])),
    .cfg     (cfg),
    .out_vld (f_vld),
    .side_a  (side_a),
    .side_b  (side_b)
  );

  cgc_log u_log_a (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (f_vld),
    .side     (side_a),
    .exponent (cfg.exponent),
    .out_vld  (la_vld),
    .lg       (lg_a)
  );

  cgc_log u_log_b (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (f_vld),
    .side     (side_b),
    .exponent (cfg.exponent),
    .out_vld  (lb_vld),
    .lg       (lg_b)
  );

  cgc_exp u_exp_a (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (la_vld),
    .lg       (lg_a),
    .exponent (cfg.exponent),
    .out_vld  (ea_vld),
    .gain     (ga)
  );

  cgc_exp u_exp_b (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (lb_vld),
    .lg       (lg_b),
    .exponent (cfg.exponent),
    .out_vld  (eb_vld),
    .gain     (gb)
  );

  cgc_norm u_norm (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (ea_vld && eb_vld),
    .ga      (ga),
    .gb      (gb),
    .cp      (cfg.cp),
    .swap    (cfg.swap),
    .out_vld (m_tvalid),
    .gain_a  (gain_a),
    .gain_b  (gain_b)
  );

  assign m_tdata = {gain_b, gain_a};

endmodule

// File: design/cgc_checker.sv
// ----------------------------------------------------------------------------
// Crossfader gain curve checker
// Port level assertions on the streaming handshake and the gain range.
// ----------------------------------------------------------------------------
module cgc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [23:0]                    s_tdata,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [31:0]                    m_tdata,
  input logic                           cfg_wr_en,
  input logic [cgc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [cgc_pkg::CFG_DATA_W-1:0] cfg_data
);

  a_reset_empty : assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid right after reset");

  a_hold : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  a_backpressure : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while the pipeline is stalled");

  a_gain_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:0] <= 16'd32768) && (m_tdata[31:16] <= 16'd32768))
    else $error("gain above unity");

endmodule

bind crossfader_gain_curve cgc_checker u_cgc_checker (.*);
